### rtl/aba_pkg.sv
// Shared constants, codes and helpers for the aligned bitmap run allocator.
package aba_pkg;

  // Bitmap word geometry: one memory row holds this many in-use bits.
  localparam int WORD_W = 64;
  localparam int OFF_W  = 6;

  // Field widths of the request and result ports.
  localparam int ORDER_W = 4;
  localparam int LEN_W   = 6;
  localparam int INDEX_W = 11;
  localparam int SLOT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int LOG_W   = 3;

  // Entry counts up to 2048 inclusive need one bit more than an index.
  localparam int ENT_W = 12;

  // Table order limits.
  localparam logic [ORDER_W-1:0] MIN_ORDER   = 4'd8;
  localparam logic [ORDER_W-1:0] MAX_ORDER   = 4'hB;
  localparam logic [ORDER_W-1:0] RESET_ORDER = 4'hB;

  // Request functions.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  // Base-two log of a power-of-two run length; other lengths never reach use.
  function automatic logic [LOG_W-1:0] run_log2(input logic [LEN_W-1:0] len);
    logic [LOG_W-1:0] r;
    case (len)
      6'd2:    r = 3'd1;
      6'd4:    r = 3'd2;
      6'd8:    r = 3'd3;
      6'd16:   r = 3'd4;
      6'd32:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/aba_ram.sv
// Generic single-write, single-read memory with a registered read port.
module aba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/aligned_bitmap_run_allocator.sv
// Top level of the aligned power-of-two run allocator over an in-use bitmap.
//
//   channel   ports                               transfer when
//   request   func, run_length, start_index       start high and busy low
//   result    status, slot                        done high (one cycle)
//   config    cfg_wr_data                         cfg_wr_en high
//
// An allocate issues the first read, then examines one 64-bit word after another
// through the shared word evaluator, up to 2^table_order / 64 words: 4 to 32.
// A free does one read-modify-write per touched word, one or two words; a bad
// length or range is refused in idle. done rises in the cycle after the last step.
// Reset clears the bitmap at once through per-word valid bits; no sweep.
// The receiver cannot stall; busy is low again in the cycle done is shown.
module aligned_bitmap_run_allocator #(
  parameter int MAX_ENTRIES = 2048,
  parameter int MAX_RUN     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [aba_pkg::ORDER_W-1:0]   cfg_wr_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [aba_pkg::LEN_W-1:0]     run_length,
  input  logic [aba_pkg::INDEX_W-1:0]   start_index,
  output logic                          done,
  output logic [aba_pkg::STATUS_W-1:0]  status,
  output logic [aba_pkg::SLOT_W-1:0]    slot
);

  localparam int W     = aba_pkg::WORD_W;
  localparam int WORDS = (MAX_ENTRIES + aba_pkg::WORD_W - 1) / aba_pkg::WORD_W;
  localparam int AW    = $clog2(WORDS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_FREE_LO = 3'd2;
  localparam logic [2:0] S_FREE_HI = 3'd3;

  logic [2:0]                      state, state_next;
  logic [aba_pkg::ORDER_W-1:0]     table_order;
  logic [aba_pkg::LEN_W-1:0]       req_len;
  logic [aba_pkg::LOG_W-1:0]       req_log;
  logic [aba_pkg::OFF_W-1:0]       req_off;
  logic [AW-1:0]                   word_addr;
  logic [WORDS-1:0]                row_valid;
  logic                            done_next;
  logic [aba_pkg::STATUS_W-1:0]    status_next;
  logic [aba_pkg::SLOT_W-1:0]      slot_next;

  logic [AW-1:0]                   raddr;
  logic                            we;
  logic [W-1:0]                    wdata;
  logic [W-1:0]                    rdata;
  logic [W-1:0]                    word;

  logic [aba_pkg::ORDER_W-1:0]     ord_c;
  logic [aba_pkg::ENT_W-1:0]       entries;
  logic [AW-1:0]                   last_word;
  logic                            accept;
  logic                            len_ok;
  logic                            free_fits;
  logic [AW-1:0]                   start_word;

  logic [aba_pkg::ENT_W-1:0]       rem;
  logic [W-1:0]                    in_mask;
  logic [W-1:0]                    occ;
  logic [W-1:0]                    run_free [6];
  logic [W-1:0]                    cand;
  logic                            found;
  logic [aba_pkg::OFF_W-1:0]       hit_off;
  logic [W-1:0]                    len_mask;
  logic [2*W-1:0]                  free_mask;

  aba_ram #(
    .WIDTH (W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (word_addr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Table size from the clamped order, capped at the bitmap depth.
  always_comb begin
    ord_c = table_order;
    if (ord_c < aba_pkg::MIN_ORDER) begin
      ord_c = aba_pkg::MIN_ORDER;
    end
    if (ord_c > aba_pkg::MAX_ORDER) begin
      ord_c = aba_pkg::MAX_ORDER;
    end
    entries = aba_pkg::ENT_W'(1) << ord_c;
    if (entries > aba_pkg::ENT_W'(MAX_ENTRIES)) begin
      entries = aba_pkg::ENT_W'(MAX_ENTRIES);
    end
    last_word = AW'((entries - aba_pkg::ENT_W'(1)) >> aba_pkg::OFF_W);
  end

  // Request checks done at acceptance.
  assign accept     = start && !busy;
  assign len_ok     = (run_length != '0) &&
                      (run_length <= aba_pkg::LEN_W'(MAX_RUN)) &&
                      ((run_length & (run_length - aba_pkg::LEN_W'(1))) == '0);
  assign free_fits  = ({1'b0, start_index} + aba_pkg::ENT_W'(run_length)) <= entries;
  assign start_word = AW'(start_index >> aba_pkg::OFF_W);
  assign busy       = (state != S_IDLE);

  // A word never written since reset reads as all free.
  assign word = row_valid[word_addr] ? rdata : '0;

  // Shared word evaluator: mark bits past the table as taken, then find the
  // lowest aligned free run of the requested length within the word.
  always_comb begin
    rem = entries - {word_addr, aba_pkg::OFF_W'(0)};
    if (rem >= aba_pkg::ENT_W'(W)) begin
      in_mask = '1;
    end else begin
      in_mask = (W'(1) << rem[aba_pkg::OFF_W-1:0]) - W'(1);
    end
    occ = word | ~in_mask;
    run_free[0] = ~occ;
    for (int k = 1; k < 6; k++) begin
      for (int b = 0; b < W; b++) begin
        if (b + (1 << (k - 1)) < W) begin
          run_free[k][b] = run_free[k-1][b] & run_free[k-1][b + (1 << (k - 1))];
        end else begin
          run_free[k][b] = 1'b0;
        end
      end
    end
    for (int b = 0; b < W; b++) begin
      cand[b] = run_free[req_log][b] &&
                ((aba_pkg::OFF_W'(b) & aba_pkg::OFF_W'(req_len - aba_pkg::LEN_W'(1))) == '0);
    end
    found   = 1'b0;
    hit_off = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        found   = 1'b1;
        hit_off = aba_pkg::OFF_W'(b);
      end
    end
    len_mask  = (W'(1) << req_len) - W'(1);
    free_mask = {{W{1'b0}}, len_mask} << req_off;
  end

  // Sequencer: read address, write, and the next result.
  always_comb begin
    state_next  = state;
    raddr       = '0;
    we          = 1'b0;
    wdata       = word;
    done_next   = 1'b0;
    status_next = aba_pkg::ST_OK;
    slot_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!len_ok || (func == aba_pkg::FUNC_FREE && !free_fits)) begin
            done_next   = 1'b1;
            status_next = aba_pkg::ST_BAD;
          end else if (func == aba_pkg::FUNC_ALLOC) begin
            raddr      = '0;
            state_next = S_SCAN;
          end else begin
            raddr      = start_word;
            state_next = S_FREE_LO;
          end
        end
      end
      S_SCAN: begin
        raddr = word_addr + AW'(1);
        if (found) begin
          we          = 1'b1;
          wdata       = word | (len_mask << hit_off);
          done_next   = 1'b1;
          status_next = aba_pkg::ST_OK;
          slot_next   = aba_pkg::SLOT_W'({word_addr, hit_off});
          state_next  = S_IDLE;
        end else if (word_addr == last_word) begin
          done_next   = 1'b1;
          status_next = aba_pkg::ST_NOSPACE;
          state_next  = S_IDLE;
        end
      end
      S_FREE_LO: begin
        raddr = word_addr + AW'(1);
        we    = 1'b1;
        wdata = word & ~free_mask[W-1:0];
        if (free_mask[2*W-1:W] == '0) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FREE_HI;
        end
      end
      S_FREE_HI: begin
        we         = 1'b1;
        wdata      = word & ~free_mask[2*W-1:W];
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_order <= aba_pkg::RESET_ORDER;
      row_valid   <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_wr_en) begin
        table_order <= cfg_wr_data;
      end
      if (we) begin
        row_valid[word_addr] <= 1'b1;
      end
    end
  end

  // Request fields, read address tracking and result payload.
  always_ff @(posedge clk) begin
    word_addr <= raddr;
    if (accept) begin
      req_len <= run_length;
      req_log <= aba_pkg::run_log2(run_length);
      req_off <= start_index[aba_pkg::OFF_W-1:0];
    end
    if (done_next) begin
      status <= status_next;
      slot   <= slot_next;
    end
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the aligned bitmap run allocator.
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_CAP   = 2048;
  localparam int RUN_CAP     = 32;
  localparam int IDLE_LIMIT  = 1000;
  localparam int END_SETTLE  = 40;

  typedef struct packed {
    logic [aba_pkg::STATUS_W-1:0] status;
    logic [aba_pkg::SLOT_W-1:0]   slot;
  } alloc_outcome_t;

  typedef struct {
    int base;
    int len;
  } granted_run_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [aba_pkg::ORDER_W-1:0]  cfg_wr_data = '0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         func = aba_pkg::FUNC_ALLOC;
  logic [aba_pkg::LEN_W-1:0]    run_length = '0;
  logic [aba_pkg::INDEX_W-1:0]  start_index = '0;
  logic                         done;
  logic [aba_pkg::STATUS_W-1:0] status;
  logic [aba_pkg::SLOT_W-1:0]   slot;

  // Shadow copy of the block state used to work out each outcome.
  logic [TABLE_CAP-1:0]        in_use = '0;
  logic [aba_pkg::ORDER_W-1:0] table_order = aba_pkg::RESET_ORDER;

  alloc_outcome_t outcomes_due[$];
  granted_run_t   granted_runs[$];
  int             mismatches = 0;
  int             idle_cycles = 0;

  aligned_bitmap_run_allocator #(
    .MAX_ENTRIES(TABLE_CAP),
    .MAX_RUN    (RUN_CAP)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .run_length (run_length),
    .start_index(start_index),
    .done       (done),
    .status     (status),
    .slot       (slot)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Number of entries covered by the current order, with out-of-range orders clamped.
  function automatic int table_entries();
    int n;
    if (table_order < aba_pkg::MIN_ORDER) begin
      n = 1 << aba_pkg::MIN_ORDER;
    end else if (table_order > aba_pkg::MAX_ORDER) begin
      n = 1 << aba_pkg::MAX_ORDER;
    end else begin
      n = 1 << table_order;
    end
    if (n > TABLE_CAP) begin
      n = TABLE_CAP;
    end
    return n;
  endfunction

  // Applies one request to the shadow bitmap and returns the outcome it yields.
  function automatic alloc_outcome_t alloc_outcome(input logic f,
                                                   input logic [aba_pkg::LEN_W-1:0] len,
                                                   input logic [aba_pkg::INDEX_W-1:0] idx);
    alloc_outcome_t r;
    int entries;
    int n;
    int s;
    bit fits;
    entries  = table_entries();
    n        = int'(len);
    r.status = aba_pkg::ST_OK;
    r.slot   = '0;
    if (n == 0 || n > RUN_CAP || (n & (n - 1)) != 0) begin
      r.status = aba_pkg::ST_BAD;
    end else if (f == aba_pkg::FUNC_ALLOC) begin
      // Lowest aligned run that is entirely free wins.
      r.status = aba_pkg::ST_NOSPACE;
      for (s = 0; s + n <= entries; s += n) begin
        fits = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (in_use[s + i]) fits = 1'b0;
        end
        if (fits) begin
          for (int i = 0; i < n; i++) in_use[s + i] = 1'b1;
          r.status = aba_pkg::ST_OK;
          r.slot   = s[aba_pkg::SLOT_W-1:0];
          break;
        end
      end
    end else if (int'(idx) + n > entries) begin
      r.status = aba_pkg::ST_BAD;
    end else begin
      for (int i = 0; i < n; i++) in_use[int'(idx) + i] = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one request after an optional gap and records its outcome on transfer.
  task automatic send_request(input logic f, input logic [aba_pkg::LEN_W-1:0] len,
                              input logic [aba_pkg::INDEX_W-1:0] idx, input int gap);
    alloc_outcome_t r;
    granted_run_t g;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= f;
    run_length  <= len;
    start_index <= idx;
    do @(negedge clk); while (busy);
    @(posedge clk);
    r = alloc_outcome(f, len, idx);
    outcomes_due.push_back(r);
    if (f == aba_pkg::FUNC_ALLOC && r.status == aba_pkg::ST_OK) begin
      g.base = int'(r.slot);
      g.len  = int'(len);
      granted_runs.push_back(g);
    end
  endtask

  // Stops offering requests and waits until every outcome has arrived.
  task automatic drain_results();
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(input logic [aba_pkg::ORDER_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    table_order = value;
  endtask

  // Mostly back-to-back requests, with short gaps and an occasional long one.
  function automatic int next_gap(input bit idle_on);
    int p;
    if (!idle_on) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Field extremes and the refused lengths and ranges at the reset order.
  task automatic test_field_extremes();
    send_request(aba_pkg::FUNC_ALLOC, 6'd1, 11'd0, 0);
    send_request(aba_pkg::FUNC_ALLOC, 6'd32, 11'd0, 0);
    send_request(aba_pkg::FUNC_ALLOC, 6'd2, 11'd2047, 1);
    send_request(aba_pkg::FUNC_ALLOC, 6'd0, 11'd0, 0);
    send_request(aba_pkg::FUNC_ALLOC, 6'd3, 11'd0, 0);
    send_request(aba_pkg::FUNC_ALLOC, 6'd33, 11'd0, 2);
    send_request(aba_pkg::FUNC_ALLOC, 6'd63, 11'd2047, 0);
    send_request(aba_pkg::FUNC_FREE, 6'd48, 11'd0, 0);
    // Unaligned free that also covers entries already free.
    send_request(aba_pkg::FUNC_FREE, 6'd4, 11'd1, 0);
    // Free running past the last entry.
    send_request(aba_pkg::FUNC_FREE, 6'd2, 11'd2047, 0);
    send_request(aba_pkg::FUNC_FREE, 6'd1, 11'd2047, 3);
    send_request(aba_pkg::FUNC_FREE, 6'd32, 11'd2016, 0);
  endtask

  // A low order value clamps to the smallest table, which then runs out of space.
  task automatic test_no_space();
    write_order(4'd0);
    repeat (8) send_request(aba_pkg::FUNC_ALLOC, 6'd32, 11'd0, 0);
  endtask

  // A high order value clamps to the largest table; lowering it hides used upper entries.
  task automatic test_order_change();
    write_order(4'd15);
    send_request(aba_pkg::FUNC_ALLOC, 6'd32, 11'd0, 0);
    send_request(aba_pkg::FUNC_FREE, 6'd2, 11'd255, 0);
    write_order(aba_pkg::MIN_ORDER);
    send_request(aba_pkg::FUNC_FREE, 6'd32, 11'd256, 0);
    send_request(aba_pkg::FUNC_ALLOC, 6'd1, 11'd0, 0);
  endtask

  // Random traffic: mostly grants and frees of granted runs, plus loose frees and noise.
  task automatic test_random_phase(input logic [aba_pkg::ORDER_W-1:0] order, input int count,
                                   input int alloc_pct, input bit idle_on);
    int pick;
    int k;
    logic f;
    logic [aba_pkg::LEN_W-1:0] len;
    logic [aba_pkg::INDEX_W-1:0] idx;
    write_order(order);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        f   = 1'($urandom_range(1));
        len = aba_pkg::LEN_W'($urandom_range(63));
        idx = aba_pkg::INDEX_W'($urandom_range(2047));
      end else if (pick < 18) begin
        f   = aba_pkg::FUNC_FREE;
        len = 6'd1 << $urandom_range(5);
        idx = aba_pkg::INDEX_W'($urandom_range(table_entries() - 1));
      end else if ($urandom_range(99) < alloc_pct || granted_runs.size() == 0) begin
        f   = aba_pkg::FUNC_ALLOC;
        len = 6'd1 << $urandom_range(5);
        idx = aba_pkg::INDEX_W'($urandom_range(2047));
      end else begin
        k   = $urandom_range(granted_runs.size() - 1);
        f   = aba_pkg::FUNC_FREE;
        len = aba_pkg::LEN_W'(granted_runs[k].len);
        idx = aba_pkg::INDEX_W'(granted_runs[k].base);
        granted_runs.delete(k);
      end
      send_request(f, len, idx, next_gap(idle_on));
    end
  endtask

  // Each result transfer is checked against the oldest outcome due.
  always @(negedge clk) begin : check_results
    alloc_outcome_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result status %0d slot %0d with nothing due",
                                  status, slot));
      end else begin
        want = outcomes_due.pop_front();
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
        end
        if (slot !== want.slot) begin
          report_mismatch($sformatf("slot %0d, wanted %0d", slot, want.slot));
        end
      end
    end
  end

  // Ends the run when no transfer happens for too long.
  always @(negedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_no_space();
    test_order_change();
    test_random_phase(aba_pkg::MAX_ORDER, 300, 60, 1'b1);
    test_random_phase(aba_pkg::MIN_ORDER, 250, 50, 1'b1);
    test_random_phase(4'd9, 250, 55, 1'b0);
    test_random_phase(4'd13, 250, 40, 1'b1);
    test_random_phase(4'd10, 250, 50, 1'b1);
    test_random_phase(4'd3, 200, 50, 1'b1);
    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/aba_pkg.sv
rtl/aba_ram.sv
rtl/aligned_bitmap_run_allocator.sv
dv/testbench.sv
